// ===== rtl/tcf_pkg.sv =====
// shared types and constants for the tilt complementary filter
package tcf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ACC_FRAC     = 16;
    localparam int PRE_SHIFT    = 14;
    localparam int CW           = 36;   // cordic datapath width
    localparam int AW           = 26;   // angle accumulator width
    localparam int STEP_W       = 4;

    localparam logic [8:0]  WEIGHT_RESET = 9'd238;
    localparam logic [15:0] SENS_RESET   = 16'd131;
    localparam logic [0:0]  REG_WEIGHT   = 1'b0;
    localparam logic [0:0]  REG_SENS     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RUN, ST_DIV, ST_BLEND, ST_OUT
    } tcf_state_t;

    typedef enum logic [1:0] {
        PH_IDLE, PH_LOAD, PH_DIV
    } tcf_phase_t;

    typedef struct packed {
        logic start;
        logic done;
    } tcf_lane_ctl_t;

    function automatic logic signed [AW-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [AW-1:0] r;
        begin
            unique case (i)
                4'd0:  r = 26'sd2949120;
                4'd1:  r = 26'sd1740967;
                4'd2:  r = 26'sd919879;
                4'd3:  r = 26'sd466945;
                4'd4:  r = 26'sd234379;
                4'd5:  r = 26'sd117304;
                4'd6:  r = 26'sd58666;
                4'd7:  r = 26'sd29335;
                4'd8:  r = 26'sd14668;
                4'd9:  r = 26'sd7334;
                4'd10: r = 26'sd3667;
                4'd11: r = 26'sd1833;
                4'd12: r = 26'sd917;
                4'd13: r = 26'sd458;
                4'd14: r = 26'sd229;
                default: r = 26'sd115;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/tcf_cordic_lane.sv =====
// one iterative vectoring cordic lane giving atan2(y, x) in degrees
module tcf_cordic_lane #(
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcf_pkg::tcf_lane_ctl_t ctl,
    input  logic signed [15:0]  y_in,
    input  logic signed [15:0]  x_in,
    output logic                busy,
    output logic signed [15:0]  angle
);
    import tcf_pkg::*;

    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int LIM_RAW = 180 * (1 << ANGLE_FRAC_BITS);
    localparam int LIM = (LIM_RAW > 32767) ? 32767 : LIM_RAW;

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 zero_reg, zero_next;
    logic signed [CW-1:0] xs, ys, dx, dy;
    logic signed [AW:0]   rnd;
    logic signed [AW:0]   q;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        acc_next = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        xs = CW'(x_in) <<< PRE_SHIFT;
        ys = CW'(y_in) <<< PRE_SHIFT;
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        if (ctl.start)
        begin
            zero_next = (x_in == 16'sd0) && (y_in == 16'sd0);
            busy_next = 1'b1;
            step_next = '0;
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_next = ys;  y_next = -xs;  acc_next = AW'(90 <<< ACC_FRAC);
                end
                else
                begin
                    x_next = -ys; y_next = xs;   acc_next = -AW'(90 <<< ACC_FRAC);
                end
            end
            else
            begin
                x_next = xs; y_next = ys; acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + dx; y_next = y_reg - dy;
                acc_next = acc_reg + atan_entry(step_reg);
            end
            else
            begin
                x_next = x_reg - dx; y_next = y_reg + dy;
                acc_next = acc_reg - atan_entry(step_reg);
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        acc_reg <= acc_next;
        zero_reg <= zero_next;
    end

    always_comb
    begin
        if (SH > 0)
            rnd = ((AW+1)'(acc_reg) + ((AW+1)'(1) <<< (SH - 1))) >>> SH;
        else
            rnd = (AW+1)'(acc_reg) <<< (-SH);
        if (zero_reg)
            q = '0;
        else if (rnd > LIM)
            q = (AW+1)'(LIM);
        else if (rnd < -LIM)
            q = -(AW+1)'(LIM);
        else
            q = rnd;
    end

    assign busy  = busy_reg;
    assign angle = q[15:0];
endmodule

// ===== rtl/tcf_merge.sv =====
// gyro delta divider and complementary blend of both axes; the first item loads the accel angles instead
module tcf_merge #(
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcf_pkg::tcf_lane_ctl_t ctl,
    input  logic                first,
    input  logic [8:0]          weight,
    input  logic [15:0]         sens,
    input  logic signed [15:0]  gyro_x,
    input  logic signed [15:0]  gyro_y,
    input  logic [19:0]         elapsed_us,
    input  logic signed [15:0]  accel_angle_x,
    input  logic signed [15:0]  accel_angle_y,
    output logic                busy,
    output logic signed [15:0]  fused_angle_x,
    output logic signed [15:0]  fused_angle_y
);
    import tcf_pkg::*;

    localparam int NW = 36 + ANGLE_FRAC_BITS;   // numerator width
    localparam int DW = 36;                     // sens * 1e6 width
    localparam int CNT_W = $clog2(NW + 1);
    localparam int DLT_W = 17 + ANGLE_FRAC_BITS; // signed gyro delta width
    localparam int VW = DLT_W + 12;             // blend sum width
    localparam int LIM_RAW = 180 * (1 << ANGLE_FRAC_BITS);
    localparam int LIM = (LIM_RAW > 32767) ? 32767 : LIM_RAW;

    // one shared restoring divider runs x then y
    logic [NW-1:0]   num_reg, num_next;
    logic [DW:0]     rem_reg, rem_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic            axis_reg, axis_next;
    tcf_phase_t      phase_reg, phase_next;
    logic signed [DLT_W-1:0] dlt_x_reg, dlt_x_next;
    logic signed [15:0] fx_reg, fx_next, fy_reg, fy_next;
    logic [15:0]     mag_x, mag_y, mag;
    logic [DW:0]     trial, rem_sh;
    logic [NW-1:0]   num_init;
    logic [35:0]     prod;
    logic [15:0]     sens_eff;
    logic [NW-1:0]   q_rounded;
    logic signed [DLT_W-1:0] delta;

    assign mag_x = gyro_x[15] ? 16'(-gyro_x) : 16'(gyro_x);
    assign mag_y = gyro_y[15] ? 16'(-gyro_y) : 16'(gyro_y);
    assign mag   = axis_reg ? mag_y : mag_x;
    assign sens_eff = (sens == 16'd0) ? 16'd1 : sens;
    assign prod = 36'(mag) * 36'(elapsed_us);

    // rounded numerator: (mag*dt << F) + den/2
    assign num_init = (NW'(prod) << ANGLE_FRAC_BITS) + NW'(den_reg >> 1);
    assign rem_sh = {rem_reg[DW-1:0], num_reg[NW-1]};
    assign trial  = rem_sh - {1'b0, den_reg};
    assign q_rounded = num_reg;

    function automatic logic signed [15:0] mix(input logic signed [15:0] prev,
                                               input logic signed [DLT_W-1:0] d,
                                               input logic signed [15:0] acc,
                                               input logic [8:0] w);
        logic [8:0] we;
        logic signed [VW-1:0] v;
        logic signed [VW-9:0] s;
        begin
            we = (w > 9'd256) ? 9'd256 : w;
            v = VW'($signed({1'b0, we})) * (VW'(prev) + VW'(d))
              + VW'($signed(10'd256 - {1'b0, we})) * VW'(acc) + VW'(128);
            s = (VW-8)'(v >>> 8);
            if (s > LIM)
                return 16'(LIM);
            else if (s < -LIM)
                return -16'(LIM);
            else
                return s[15:0];
        end
    endfunction

    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        axis_next = axis_reg;
        phase_next = phase_reg;
        dlt_x_next = dlt_x_reg;
        fx_next = fx_reg;
        fy_next = fy_reg;
        // quotient always fits below 2^(16+F)
        delta = $signed({1'b0, q_rounded[DLT_W-2:0]});
        if ((axis_reg ? gyro_y[15] : gyro_x[15]))
            delta = -delta;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (ctl.start)
                begin
                    if (first)
                    begin
                        fx_next = accel_angle_x;
                        fy_next = accel_angle_y;
                    end
                    else
                    begin
                        den_next = DW'(sens_eff) * DW'(20'd1000000);
                        axis_next = 1'b0;
                        phase_next = PH_LOAD;
                    end
                end
            end
            PH_LOAD:
            begin
                num_next = num_init;
                rem_next = '0;
                cnt_next = CNT_W'(NW);
                phase_next = PH_DIV;
            end
            PH_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (!trial[DW])
                    begin
                        rem_next = trial;
                        num_next = {num_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        num_next = {num_reg[NW-2:0], 1'b0};
                    end
                end
                else if (!axis_reg)
                begin
                    dlt_x_next = delta;
                    axis_next = 1'b1;
                    phase_next = PH_LOAD;
                end
                else
                begin
                    fx_next = mix(fx_reg, dlt_x_reg, accel_angle_x, weight);
                    fy_next = mix(fy_reg, delta, accel_angle_y, weight);
                    phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            fx_reg <= '0;
            fy_reg <= '0;
            cnt_reg <= '0;
            axis_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            fx_reg <= fx_next;
            fy_reg <= fy_next;
            cnt_reg <= cnt_next;
            axis_reg <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        dlt_x_reg <= dlt_x_next;
    end

    assign busy = (phase_reg != PH_IDLE) || (ctl.start && !first);
    assign fused_angle_x = fx_reg;
    assign fused_angle_y = fy_reg;
endmodule

// ===== rtl/tilt_complementary_filter_unit.sv =====
// one item at a time: the two cordic lanes run 16 steps, then the shared bit-serial
// gyro divider (NW = 36 + ANGLE_FRAC_BITS numerator bits) runs x and y; on the first
// item it does not run and the accel angles are loaded as the filtered angles
// a new item is accepted only once the last result is loaded, which waits while an earlier result is not taken
// reset: weight 238, sensitivity 131, filtered angles zero, next item loads accel angles
module tilt_complementary_filter_unit #(
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_us, pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,  // accel_angle_x, accel_angle_y, fused_angle_x, fused_angle_y
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import tcf_pkg::*;

    tcf_state_t state_reg, state_next;
    logic [8:0]   weight_reg;
    logic [15:0]  sens_reg;
    logic         first_reg, first_next;
    logic [103:0] in_reg;
    logic         in_load;
    logic [63:0]  out_reg;
    logic         out_load;
    logic         out_valid_reg, out_valid_next;
    tcf_lane_ctl_t lane_ctl, merge_ctl;
    logic         busy_x, busy_y, merge_busy;
    logic signed [15:0] ang_x, ang_y, fus_x, fus_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
            sens_reg <= SENS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WEIGHT: weight_reg <= cfg_data[8:0];
                REG_SENS:   sens_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        out_valid_next = out_valid_reg;
        s_tready = 1'b0;
        in_load = 1'b0;
        out_load = 1'b0;
        lane_ctl = '0;
        merge_ctl = '0;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    in_load = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                lane_ctl.start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!busy_x && !busy_y)
                begin
                    merge_ctl.start = 1'b1;
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                if (!merge_busy)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    out_valid_next = 1'b1;
                    first_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
            in_reg <= s_tdata;
        if (out_load)
            out_reg <= {fus_y, fus_x, ang_y, ang_x};
    end

    tcf_cordic_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_x (
        .clk(clk), .rst_n(rst_n), .ctl(lane_ctl),
        .y_in(in_reg[15:0]), .x_in(in_reg[47:32]),
        .busy(busy_x), .angle(ang_x)
    );

    tcf_cordic_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_y (
        .clk(clk), .rst_n(rst_n), .ctl(lane_ctl),
        .y_in(in_reg[31:16]), .x_in(in_reg[47:32]),
        .busy(busy_y), .angle(ang_y)
    );

    tcf_merge #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_merge (
        .clk(clk), .rst_n(rst_n), .ctl(merge_ctl), .first(first_reg),
        .weight(weight_reg), .sens(sens_reg),
        .gyro_x(in_reg[63:48]), .gyro_y(in_reg[79:64]), .elapsed_us(in_reg[99:80]),
        .accel_angle_x(ang_x), .accel_angle_y(ang_y),
        .busy(merge_busy), .fused_angle_x(fus_x), .fused_angle_y(fus_y)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("ready while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctl.start |=> (busy_x && busy_y)) else $error("lanes not started");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> !first_reg) else $error("first sample flag kept");
endmodule
